@@ rtl/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the breathing LED and beep sequencer.
// ----------------------------------------------------------------------------
package bls_pkg;

  // Opcodes
  localparam logic [1:0] OpUpdate = 2'd0;
  localparam logic [1:0] OpLed    = 2'd1;
  localparam logic [1:0] OpBeep   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] RegBeepOn     = 2'd0;
  localparam logic [1:0] RegBeepOff    = 2'd1;
  localparam logic [1:0] RegFullScale  = 2'd2;
  localparam logic [1:0] RegMinPeriod  = 2'd3;

  // Reset values
  localparam logic [15:0] BeepOnRst     = 16'd100;
  localparam logic [15:0] BeepOffRst    = 16'd100;
  localparam logic [15:0] FullScaleRst  = 16'd999;
  localparam logic [15:0] MinPeriodRst  = 16'd20;
  localparam logic [15:0] PeriodRst     = 16'd2000;
  localparam logic [31:0] LastChangeRst = 32'd0 - 32'd100;
  localparam logic [15:0] PeriodFloor   = 16'd2;
  localparam logic [7:0]  BeepMark      = 8'h01;

  // Divider geometry: 32-bit dividend, 16-bit divisor, one bit per step
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [15:0] remainder;
  } bls_div_res_t;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StStep = 6'b000010,
    StMod  = 6'b000100,
    StMul  = 6'b001000,
    StQuo  = 6'b010000,
    StDone = 6'b100000
  } bls_state_e;

endpackage

@@ rtl/bls_div.sv @@
// ----------------------------------------------------------------------------
// bls_div
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit unsigned.
// ----------------------------------------------------------------------------
module bls_div import bls_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [31:0]  dividend_i,
  input  logic [15:0]  divisor_i,
  output bls_div_res_t res_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [31:0]        quo_q, quo_d;
  logic [15:0]        rem_q, rem_d;
  logic [15:0]        den_q, den_d;
  logic [16:0]        trial;
  logic [16:0]        diff;
  logic               fits;

  always_comb begin
    trial = {rem_q, quo_q[31]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      // shift the next dividend bit in, subtract when the divisor fits
      rem_d = fits ? diff[15:0] : trial[15:0];
      quo_d = {quo_q[30:0], fits};
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

@@ rtl/breathing_led_and_beep_sequencer.sv @@
// ----------------------------------------------------------------------------
// breathing_led_and_beep_sequencer
// Triangle-wave LED breathing compare value and beep on/off timing.
// ----------------------------------------------------------------------------
// One transaction in gives one result out. While breathing is on, the step
// state advances the buzzer and starts one shared bit-serial divider. The
// divider then reduces the elapsed time modulo the period. The multiply state
// follows and starts the divide of the scaled ramp position by the half
// period. The done state then loads the output register. With breathing off
// the step state goes straight to the done state. The input stalls until the
// result is loaded. A result held in the output register by a stall keeps the
// done state waiting. A finished result sits in the output register and the
// next transaction may enter meanwhile.
module breathing_led_and_beep_sequencer import bls_pkg::*; #(
  parameter int unsigned BEEP_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input transactions
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  led_enable_i,
  input  logic [15:0] led_period_i,
  input  logic [63:0] beep_payload_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pwm_compare_o,
  output logic        buzzer_drive_o
);

  bls_state_e   state_q, state_d;

  logic [15:0]  beep_on_q, beep_off_q, full_scale_q, min_period_q;

  logic         breathing_q, breathing_d;
  logic [15:0]  period_q, period_d;
  logic [31:0]  phase_start_q, phase_start_d;
  logic [3:0]   beeps_left_q, beeps_left_d;
  logic         beeping_q, beeping_d;
  logic [31:0]  last_change_q, last_change_d;

  logic [31:0]  now_q, now_d;
  logic [15:0]  x_q, x_d;
  logic [15:0]  den_q, den_d;
  logic [15:0]  pwm_res_q, pwm_res_d;

  logic         out_valid_q, out_valid_d;
  logic [15:0]  pwm_out_q, pwm_out_d;
  logic         buzz_out_q, buzz_out_d;

  logic         in_accept;
  logic [15:0]  floor_p;
  logic [3:0]   beep_count;
  logic [31:0]  elapsed;
  logic [15:0]  half_p;
  logic [15:0]  ph;
  logic         rising;
  logic [31:0]  product;
  logic         out_free;

  logic         div_start;
  logic [31:0]  div_dividend;
  logic [15:0]  div_divisor;
  bls_div_res_t div_res;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  // count payload bytes that mark one beep
  always_comb begin
    beep_count = '0;
    for (int i = 0; i < BEEP_BYTES && i < 8; i++) begin
      if (beep_payload_i[8*i +: 8] == BeepMark) begin
        beep_count = beep_count + 4'd1;
      end
    end
  end

  assign floor_p = (min_period_q < PeriodFloor) ? PeriodFloor : min_period_q;
  assign elapsed = now_q - last_change_q;
  assign half_p  = period_q >> 1;
  assign ph      = div_res.remainder;
  assign rising  = ph < half_p;
  assign product = x_q * full_scale_q;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = now_q - phase_start_q;
    div_divisor  = period_q;
    if (state_q == StStep && breathing_q) begin
      div_start = 1'b1;
    end else if (state_q == StMul) begin
      div_start    = 1'b1;
      div_dividend = product;
      div_divisor  = den_q;
    end
  end

  bls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .res_o      (div_res)
  );

  always_comb begin
    state_d       = state_q;
    breathing_d   = breathing_q;
    period_d      = period_q;
    phase_start_d = phase_start_q;
    beeps_left_d  = beeps_left_q;
    beeping_d     = beeping_q;
    last_change_d = last_change_q;
    now_d         = now_q;
    x_d           = x_q;
    den_d         = den_q;
    pwm_res_d     = pwm_res_q;
    out_valid_d   = out_valid_q && out_stall_i;
    pwm_out_d     = pwm_out_q;
    buzz_out_d    = buzz_out_q;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          now_d   = now_ms_i;
          state_d = StStep;
          unique case (opcode_i)
            OpLed: begin
              breathing_d   = led_enable_i != 8'd0;
              period_d      = (led_period_i < floor_p) ? floor_p : led_period_i;
              phase_start_d = now_ms_i;
            end
            OpBeep: begin
              beeps_left_d  = beep_count;
              beeping_d     = 1'b0;
              last_change_d = now_ms_i;
            end
            default: begin
            end
          endcase
        end
      end
      StStep: begin
        // advance the buzzer timer
        if (beeping_q && elapsed >= {16'd0, beep_on_q}) begin
          beeping_d     = 1'b0;
          last_change_d = now_q;
          if (beeps_left_q != 4'd0) begin
            beeps_left_d = beeps_left_q - 4'd1;
          end
        end else if (!beeping_q && beeps_left_q != 4'd0 &&
                     elapsed >= {16'd0, beep_off_q}) begin
          beeping_d     = 1'b1;
          last_change_d = now_q;
        end
        if (breathing_q) begin
          state_d = StMod;
        end else begin
          pwm_res_d = '0;
          state_d   = StDone;
        end
      end
      StMod: begin
        if (div_res.done) begin
          x_d     = rising ? ph : period_q - ph;
          den_d   = rising ? half_p : period_q - half_p;
          state_d = StMul;
        end
      end
      StMul: begin
        state_d = StQuo;
      end
      StQuo: begin
        if (div_res.done) begin
          pwm_res_d = div_res.quotient[15:0];
          state_d   = StDone;
        end
      end
      StDone: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          pwm_out_d   = pwm_res_q;
          buzz_out_d  = beeping_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      beep_on_q     <= BeepOnRst;
      beep_off_q    <= BeepOffRst;
      full_scale_q  <= FullScaleRst;
      min_period_q  <= MinPeriodRst;
      breathing_q   <= 1'b0;
      period_q      <= PeriodRst;
      phase_start_q <= '0;
      beeps_left_q  <= '0;
      beeping_q     <= 1'b0;
      last_change_q <= LastChangeRst;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      breathing_q   <= breathing_d;
      period_q      <= period_d;
      phase_start_q <= phase_start_d;
      beeps_left_q  <= beeps_left_d;
      beeping_q     <= beeping_d;
      last_change_q <= last_change_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegBeepOn:    beep_on_q    <= cfg_data_i;
          RegBeepOff:   beep_off_q   <= cfg_data_i;
          RegFullScale: full_scale_q <= cfg_data_i;
          RegMinPeriod: min_period_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    x_q       <= x_d;
    den_q     <= den_d;
    pwm_res_q <= pwm_res_d;
    pwm_out_q <= pwm_out_d;
    buzz_out_q <= buzz_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pwm_compare_o  = pwm_out_q;
  assign buzzer_drive_o = buzz_out_q;

endmodule

@@ rtl/bls_chk.sv @@
// ----------------------------------------------------------------------------
// bls_chk
// Port-level checks for the breathing LED and beep sequencer.
// ----------------------------------------------------------------------------
module bls_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] pwm_compare_o,
  input logic        buzzer_drive_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pwm_compare_o) &&
                                   $stable(buzzer_drive_o))
    else $error("stalled result changed");

  // one transaction at a time: input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open while transaction in work");

  // a result never appears in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // reset leaves the block empty and ready
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("not idle in reset");

endmodule

bind breathing_led_and_beep_sequencer bls_chk u_bls_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pwm_compare_o  (pwm_compare_o),
  .buzzer_drive_o (buzzer_drive_o)
);
